// ----- design/rtufr_pkg.sv -----
// Package for the serial-bus frame receiver: phase, mode and check codes,
// register indexes, result layout and the CRC-16 byte update.
// No dependencies.
package rtufr_pkg;

  localparam int unsigned FRAME_BYTES = 255;
  localparam int unsigned MIN_FRAME   = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] RESET_GAP_INIT = 16'd1500;
  localparam logic [15:0] FRAME_GAP_INIT = 16'd3500;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_GAP      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP      = 8'd3;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_RECV  = 2'd1,
    PH_ERR   = 2'd2,
    PH_READY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_ARM   = 2'd2,
    MODE_CHECK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CHK_NONE     = 2'd0,
    CHK_ACCEPT   = 2'd1,
    CHK_ADDR_BAD = 2'd2,
    CHK_CRC_BAD  = 2'd3
  } check_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] crc_value;
    check_t      check_result;
    logic [7:0]  function_code;
    logic [7:0]  byte_count;
    phase_t      link_state;
  } result_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

  // Fold one byte into a CRC held in transmit order (first byte high).
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = swap16(acc) ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    crc_fold = swap16(r);
  endfunction

endpackage

// ----- design/rtu_frame_receiver.sv -----
// Serial-bus slave frame receiver: byte counting, silence timing, CRC-16
// and address/CRC check of a complete frame.
// Depends on rtufr_pkg.
//
// One result word per input word, registered; it is valid in the cycle after accept.
// Throughput: one word per cycle while m_axis_tready is high; the output register drains while the next word enters.
// The state update and the byte-wide CRC fold both sit between the state
// registers and the result register.
// Reset (rst, synchronous): phase off, count 0, timer 0, CRC 0xFFFF,
// registers at their defaults, output empty.
module rtu_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [1:0] link_state, [9:2] byte_count,
                                      // [17:10] function_code, [19:18] check_result,
                                      // [35:20] crc_value, [39:36] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rtufr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  device_address;
  logic [15:0] tick_step;
  logic [15:0] reset_gap;
  logic [15:0] frame_gap;

  rtufr_pkg::phase_t link_phase, link_phase_next;
  logic [7:0]  frame_count, frame_count_next;
  logic [15:0] silence_timer, silence_timer_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [15:0] newest_two, newest_two_next;
  logic [15:0] first_two, first_two_next;
  rtufr_pkg::check_t check_next;

  rtufr_pkg::result_t result;
  logic               result_valid;

  logic        in_fire;
  logic [15:0] tick_sum;
  logic [7:0]  adr;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !result_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd0;
      tick_step      <= 16'd0;
      reset_gap      <= rtufr_pkg::RESET_GAP_INIT;
      frame_gap      <= rtufr_pkg::FRAME_GAP_INIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtufr_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        rtufr_pkg::REG_TICK_STEP:      tick_step      <= cfg_data;
        rtufr_pkg::REG_RESET_GAP:      reset_gap      <= cfg_data;
        rtufr_pkg::REG_FRAME_GAP:      frame_gap      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tick_sum = silence_timer + tick_step;
  assign adr      = first_two[15:8];

  always_comb begin
    link_phase_next    = link_phase;
    frame_count_next   = frame_count;
    silence_timer_next = silence_timer;
    crc_acc_next       = crc_acc;
    newest_two_next    = newest_two;
    first_two_next     = first_two;
    check_next         = rtufr_pkg::CHK_NONE;

    case (rtufr_pkg::mode_t'(s_axis_tuser))
      rtufr_pkg::MODE_BYTE: begin
        if (link_phase == rtufr_pkg::PH_RECV) begin
          if (frame_count != 8'd0 && silence_timer >= reset_gap) begin
            link_phase_next = rtufr_pkg::PH_ERR;
          end else if (frame_count < 8'(rtufr_pkg::FRAME_BYTES)) begin
            // the two newest bytes are the frame's own CRC, kept out of the sum
            if (frame_count >= 8'd2) begin
              crc_acc_next = rtufr_pkg::crc_fold(crc_acc, newest_two[15:8]);
            end
            newest_two_next = {newest_two[7:0], s_axis_tdata};
            if (frame_count == 8'd0) begin
              first_two_next = {s_axis_tdata, first_two[7:0]};
            end else if (frame_count == 8'd1) begin
              first_two_next = {first_two[15:8], s_axis_tdata};
            end
            frame_count_next = frame_count + 8'd1;
          end
        end
        silence_timer_next = 16'd0;
      end
      rtufr_pkg::MODE_TICK: begin
        if ((link_phase == rtufr_pkg::PH_RECV || link_phase == rtufr_pkg::PH_ERR)
            && silence_timer < frame_gap) begin
          silence_timer_next = tick_sum;
          if (tick_sum >= frame_gap) begin
            if (link_phase == rtufr_pkg::PH_RECV
                && frame_count >= 8'(rtufr_pkg::MIN_FRAME)) begin
              link_phase_next = rtufr_pkg::PH_READY;
            end else begin
              link_phase_next  = rtufr_pkg::PH_RECV;
              frame_count_next = 8'd0;
              crc_acc_next     = rtufr_pkg::CRC_INIT;
              newest_two_next  = 16'd0;
              first_two_next   = 16'd0;
            end
          end
        end
      end
      rtufr_pkg::MODE_ARM: begin
        link_phase_next    = rtufr_pkg::PH_RECV;
        silence_timer_next = 16'd0;
        frame_count_next   = 8'd0;
        crc_acc_next       = rtufr_pkg::CRC_INIT;
        newest_two_next    = 16'd0;
        first_two_next     = 16'd0;
      end
      default: begin
        if (link_phase == rtufr_pkg::PH_READY) begin
          // address zero is the unset address and never matches
          if (adr == 8'd0 || adr != device_address) begin
            check_next = rtufr_pkg::CHK_ADDR_BAD;
          end else if (newest_two != crc_acc) begin
            check_next = rtufr_pkg::CHK_CRC_BAD;
          end else begin
            check_next = rtufr_pkg::CHK_ACCEPT;
          end
          if (check_next != rtufr_pkg::CHK_ACCEPT) begin
            link_phase_next    = rtufr_pkg::PH_RECV;
            silence_timer_next = 16'd0;
            frame_count_next   = 8'd0;
            crc_acc_next       = rtufr_pkg::CRC_INIT;
            newest_two_next    = 16'd0;
            first_two_next     = 16'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase    <= rtufr_pkg::PH_OFF;
      frame_count   <= 8'd0;
      silence_timer <= 16'd0;
      crc_acc       <= rtufr_pkg::CRC_INIT;
      newest_two    <= 16'd0;
      first_two     <= 16'd0;
    end else if (in_fire) begin
      link_phase    <= link_phase_next;
      frame_count   <= frame_count_next;
      silence_timer <= silence_timer_next;
      crc_acc       <= crc_acc_next;
      newest_two    <= newest_two_next;
      first_two     <= first_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_fire) begin
      result_valid <= 1'b1;
    end else if (m_axis_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result.link_state    <= link_phase_next;
      result.byte_count    <= frame_count_next;
      result.function_code <= first_two_next[7:0];
      result.check_result  <= check_next;
      result.crc_value     <= crc_acc_next;
    end
  end

  assign m_axis_tvalid = result_valid;
  assign m_axis_tdata  = {4'b0000, result};

  // an accepted frame leaves the receiver in frame-ready
  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.check_result == rtufr_pkg::CHK_ACCEPT)
      |-> result.link_state == rtufr_pkg::PH_READY)
    else $error("accepted frame not in frame-ready");

  // a failed check rearms with an empty frame
  a_mismatch_rearm: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.check_result == rtufr_pkg::CHK_ADDR_BAD
                      || result.check_result == rtufr_pkg::CHK_CRC_BAD))
      |-> (result.link_state == rtufr_pkg::PH_RECV && result.byte_count == 8'd0
           && result.crc_value == rtufr_pkg::CRC_INIT))
    else $error("mismatch did not rearm");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= 8'(rtufr_pkg::FRAME_BYTES))
    else $error("frame count past limit");

  a_off_empty: assert property (@(posedge clk) disable iff (rst)
    link_phase == rtufr_pkg::PH_OFF |-> (frame_count == 8'd0 && first_two == 16'd0))
    else $error("bytes stored while off");

  // a held result blocks the input side, so no word is overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken over a held result");

endmodule
